// ===== rtl/wfsc_pkg.sv =====
// Shared types and codes for the worker frame sequence checker.
// Holds the input and result item structs, the configuration bundle and the
// command, frame kind, terminal kind and register index codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wfsc_pkg;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_EOS   = 2'd3;

  // Frame kinds. Any other value is an unknown kind.
  localparam logic [7:0] KIND_READY     = 8'd0;
  localparam logic [7:0] KIND_PROGRESS  = 8'd1;
  localparam logic [7:0] KIND_STOPACK   = 8'd2;
  localparam logic [7:0] KIND_STOPIGN   = 8'd3;
  localparam logic [7:0] KIND_COMPLETED = 8'd4;
  localparam logic [7:0] KIND_CANCELLED = 8'd5;

  // Terminal kinds reported in the result.
  localparam logic [1:0] TERM_NONE      = 2'd0;
  localparam logic [1:0] TERM_COMPLETED = 2'd1;
  localparam logic [1:0] TERM_CANCELLED = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE   = 2'd3;

  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] frame_magic;
    logic [15:0] frame_version;
    logic [7:0]  frame_kind;
    logic [31:0] frame_iterations;
    logic [63:0] frame_value;
    logic [31:0] frame_dropped;
    logic [31:0] now_time;
    logic        stop_reached;
  } in_item_t;

  typedef struct packed {
    logic        malformed;
    logic        started;
    logic        stop_pending;
    logic        stop_acked;
    logic        stop_refused;
    logic [1:0]  terminal_kind;
    logic [31:0] progress_count;
    logic [31:0] final_iterations;
    logic [63:0] final_value;
    logic [31:0] dropped_count;
    logic        terminate_request;
  } out_item_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [31:0] total_iterations;
    logic [31:0] stop_grace;
  } cfg_t;

endpackage : wfsc_pkg

`default_nettype wire

// ===== rtl/wfsc_cfg_regs.sv =====
// Configuration register file of the worker frame sequence checker.
// Decodes the plain write port into the four setup registers.
// Depends on wfsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfsc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [wfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wfsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output wfsc_pkg::cfg_t                        cfg
);
  import wfsc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= '0;
      cfg_r.expected_version <= '0;
      cfg_r.total_iterations <= 32'd1;
      cfg_r.stop_grace       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:   cfg_r.expected_magic   <= cfg_wdata;
        REG_VERSION: cfg_r.expected_version <= cfg_wdata[15:0];
        REG_TOTAL:   cfg_r.total_iterations <= cfg_wdata;
        REG_GRACE:   cfg_r.stop_grace       <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule : wfsc_cfg_regs

`default_nettype wire

// ===== rtl/wfsc_core.sv =====
// Sequence state and per-item check logic of the worker frame sequence checker.
// Holds the protocol state registers and computes the result snapshot of one item.
// Depends on wfsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfsc_core #(
  parameter int unsigned ITER_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire wfsc_pkg::in_item_t item,
  input  wire wfsc_pkg::cfg_t     cfg,
  output wfsc_pkg::out_item_t     result
);
  import wfsc_pkg::*;

  // Counts are kept at the narrower of the field width and ITER_BITS.
  localparam int unsigned CW = (ITER_BITS < 32) ? ITER_BITS : 32;

  logic          bad_r, bad_nxt;
  logic          started_r, started_nxt;
  logic          stop_r, stop_nxt;
  logic          delivered_r, delivered_nxt;
  logic [31:0]   stop_time_r, stop_time_nxt;
  logic          ack_r, ack_nxt;
  logic          ignored_r, ignored_nxt;
  logic [1:0]    end_kind_r, end_kind_nxt;
  logic [CW-1:0] progress_r, progress_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [CW-1:0] dropped_r, dropped_nxt;
  logic [CW-1:0] end_iter_r, end_iter_nxt;
  logic [63:0]   end_value_r, end_value_nxt;
  logic          kill_r, kill_nxt;

  logic [CW-1:0] iters;
  logic [CW-1:0] dropped;
  logic [CW-1:0] total;
  logic          common_ok;
  logic          kind_ok;
  logic          frame_ok;
  logic          grace_over;
  logic [31:0]   elapsed;

  assign iters   = item.frame_iterations[CW-1:0];
  assign dropped = item.frame_dropped[CW-1:0];
  assign total   = cfg.total_iterations[CW-1:0];

  assign common_ok = (item.frame_magic == cfg.expected_magic) &&
                     (item.frame_version == cfg.expected_version) &&
                     (iters <= total) && (iters >= last_r) &&
                     (dropped <= total) && (dropped >= dropped_r) &&
                     (end_kind_r == TERM_NONE);

  always_comb begin
    case (item.frame_kind)
      KIND_READY:     kind_ok = !started_r && (iters == '0) &&
                                (item.frame_value == '0) && (dropped == '0);
      KIND_PROGRESS:  kind_ok = started_r && !ack_r && (iters > last_r);
      KIND_STOPACK,
      KIND_STOPIGN:   kind_ok = started_r && stop_r && !ack_r && !ignored_r &&
                                (iters >= progress_r);
      KIND_COMPLETED: kind_ok = started_r && !ack_r && (iters == total) &&
                                (iters >= progress_r);
      KIND_CANCELLED: kind_ok = started_r && stop_r && ack_r && (iters >= progress_r);
      default:        kind_ok = 1'b0;
    endcase
  end

  assign frame_ok = common_ok && kind_ok;

  // A clock that went backwards never expires the grace time.
  assign elapsed    = item.now_time - stop_time_r;
  assign grace_over = (item.now_time >= stop_time_r) && (elapsed >= cfg.stop_grace);

  always_comb begin
    bad_nxt       = bad_r;
    started_nxt   = started_r;
    stop_nxt      = stop_r;
    delivered_nxt = delivered_r;
    stop_time_nxt = stop_time_r;
    ack_nxt       = ack_r;
    ignored_nxt   = ignored_r;
    end_kind_nxt  = end_kind_r;
    progress_nxt  = progress_r;
    last_nxt      = last_r;
    dropped_nxt   = dropped_r;
    end_iter_nxt  = end_iter_r;
    end_value_nxt = end_value_r;
    kill_nxt      = kill_r;

    case (item.command)
      CMD_FRAME: begin
        // Once malformed, every later frame is ignored.
        if (!bad_r) begin
          if (!frame_ok) begin
            bad_nxt = 1'b1;
          end else begin
            last_nxt    = iters;
            dropped_nxt = dropped;
            case (item.frame_kind)
              KIND_READY:    started_nxt  = 1'b1;
              KIND_PROGRESS: progress_nxt = iters;
              KIND_STOPACK:  ack_nxt      = 1'b1;
              KIND_STOPIGN:  ignored_nxt  = 1'b1;
              KIND_COMPLETED: begin
                end_kind_nxt  = TERM_COMPLETED;
                end_iter_nxt  = iters;
                end_value_nxt = item.frame_value;
              end
              KIND_CANCELLED: begin
                end_kind_nxt  = TERM_CANCELLED;
                end_iter_nxt  = iters;
                end_value_nxt = item.frame_value;
              end
              default: ;
            endcase
          end
        end
      end
      CMD_STOP: begin
        if (!stop_r) begin
          stop_nxt      = 1'b1;
          stop_time_nxt = item.now_time;
          delivered_nxt = item.stop_reached;
          if (!item.stop_reached) begin
            kill_nxt = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (bad_r || (stop_r && (!delivered_r || grace_over))) begin
          kill_nxt = 1'b1;
        end
      end
      CMD_EOS: begin
        if (end_kind_r == TERM_NONE) begin
          bad_nxt = 1'b1;
        end
        if (bad_nxt || (stop_r && (!delivered_r || grace_over))) begin
          kill_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r       <= 1'b0;
      started_r   <= 1'b0;
      stop_r      <= 1'b0;
      delivered_r <= 1'b0;
      stop_time_r <= '0;
      ack_r       <= 1'b0;
      ignored_r   <= 1'b0;
      end_kind_r  <= TERM_NONE;
      progress_r  <= '0;
      last_r      <= '0;
      dropped_r   <= '0;
      end_iter_r  <= '0;
      end_value_r <= '0;
      kill_r      <= 1'b0;
    end else if (step) begin
      bad_r       <= bad_nxt;
      started_r   <= started_nxt;
      stop_r      <= stop_nxt;
      delivered_r <= delivered_nxt;
      stop_time_r <= stop_time_nxt;
      ack_r       <= ack_nxt;
      ignored_r   <= ignored_nxt;
      end_kind_r  <= end_kind_nxt;
      progress_r  <= progress_nxt;
      last_r      <= last_nxt;
      dropped_r   <= dropped_nxt;
      end_iter_r  <= end_iter_nxt;
      end_value_r <= end_value_nxt;
      kill_r      <= kill_nxt;
    end
  end

  // The result is a snapshot of the state after the item.
  always_comb begin
    result.malformed         = bad_nxt;
    result.started           = started_nxt;
    result.stop_pending      = stop_nxt;
    result.stop_acked        = ack_nxt;
    result.stop_refused      = ignored_nxt;
    result.terminal_kind     = end_kind_nxt;
    result.progress_count    = 32'(progress_nxt);
    result.final_iterations  = 32'(end_iter_nxt);
    result.final_value       = end_value_nxt;
    result.dropped_count     = 32'(dropped_nxt);
    result.terminate_request = kill_nxt;
  end

endmodule : wfsc_core

`default_nettype wire

// ===== rtl/worker_frame_sequence_checker.sv =====
// Top level of the worker frame sequence checker.
// Input register, output register and handshake; instantiates wfsc_cfg_regs
// and wfsc_core. Depends on wfsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The checker takes one item per transfer on the input channel (a frame, a
// stop request, a time tick or end of stream) and returns exactly one result
// per item: a snapshot of the sequence state after that item. An item sits in
// the input register while the frame checks and state update are evaluated,
// and its result is loaded into the output register, so a new item can be
// taken every cycle while the output side keeps up. The configuration
// registers are written through the plain write port and must only be
// changed while no item is in flight. ITER_BITS limits the width at which
// iteration and dropped counts are compared and stored.
module worker_frame_sequence_checker #(
  parameter int unsigned ITER_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire wfsc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output wfsc_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [wfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wfsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wfsc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_full_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  // An item moves on when the output register is empty or being drained.
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  wfsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wfsc_core #(
    .ITER_BITS (ITER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_take) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : worker_frame_sequence_checker

`default_nettype wire

// ===== tb/sv/worker_frame_sequence_checker_tb.sv =====
// Self-checking testbench for worker_frame_sequence_checker.
// Drives one long worker session with random stalls on both channels and predicts every
// state snapshot in place. Depends on wfsc_pkg and the checker RTL.
`timescale 1ns / 1ps

module worker_frame_sequence_checker_tb;
  import wfsc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  worker_frame_sequence_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow of the configuration and the session state.
  cfg_t cfg_shadow = '{32'd0, 16'd0, 32'd1, 32'd0};
  logic seq_bad = 1'b0;
  logic seq_started = 1'b0;
  logic stop_seen = 1'b0;
  logic stop_deliv = 1'b0;
  logic [31:0] stop_at = '0;
  logic stop_acked = 1'b0;
  logic stop_refused = 1'b0;
  logic [1:0] term_kind = TERM_NONE;
  logic [31:0] progress_iters = '0;
  logic [31:0] last_iters = '0;
  logic [31:0] last_dropped = '0;
  logic [31:0] term_iters = '0;
  logic [63:0] term_value = '0;
  logic kill_req = 1'b0;

  out_item_t pending_snapshots[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit quiet_mode = 1'b0;

  // Returns 1 when the frame is legal in the current state and applies it.
  function automatic bit accept_frame(input in_item_t it);
    logic [31:0] n;
    logic [31:0] d;
    n = it.frame_iterations;
    d = it.frame_dropped;
    if (it.frame_magic != cfg_shadow.expected_magic ||
        it.frame_version != cfg_shadow.expected_version ||
        it.frame_kind > KIND_CANCELLED ||
        n > cfg_shadow.total_iterations || n < last_iters ||
        d > cfg_shadow.total_iterations || d < last_dropped ||
        term_kind != TERM_NONE)
      return 1'b0;
    case (it.frame_kind)
      KIND_READY: begin
        if (seq_started || n != 0 || it.frame_value != 0 || d != 0) return 1'b0;
        seq_started = 1'b1;
      end
      KIND_PROGRESS: begin
        if (!seq_started || stop_acked || n <= last_iters) return 1'b0;
        progress_iters = n;
      end
      KIND_STOPACK, KIND_STOPIGN: begin
        if (!seq_started || !stop_seen || stop_acked || stop_refused || n < progress_iters)
          return 1'b0;
        if (it.frame_kind == KIND_STOPACK) stop_acked = 1'b1;
        else stop_refused = 1'b1;
      end
      KIND_COMPLETED: begin
        if (!seq_started || stop_acked || n != cfg_shadow.total_iterations ||
            n < progress_iters)
          return 1'b0;
        term_kind = TERM_COMPLETED;
        term_iters = n;
        term_value = it.frame_value;
      end
      default: begin
        if (!seq_started || !stop_seen || !stop_acked || n < progress_iters) return 1'b0;
        term_kind = TERM_CANCELLED;
        term_iters = n;
        term_value = it.frame_value;
      end
    endcase
    last_iters = n;
    last_dropped = d;
    return 1'b1;
  endfunction

  function automatic void grace_check(input logic [31:0] now);
    if (seq_bad) kill_req = 1'b1;
    if (stop_seen) begin
      if (!stop_deliv) kill_req = 1'b1;
      // A clock that went back never runs the grace out.
      else if (now >= stop_at && (now - stop_at) >= cfg_shadow.stop_grace) kill_req = 1'b1;
    end
  endfunction

  function automatic out_item_t next_snapshot(input in_item_t it);
    out_item_t s;
    case (it.command)
      CMD_FRAME: if (!seq_bad && !accept_frame(it)) seq_bad = 1'b1;
      CMD_STOP: begin
        if (!stop_seen) begin
          stop_seen = 1'b1;
          stop_at = it.now_time;
          stop_deliv = it.stop_reached;
          if (!it.stop_reached) kill_req = 1'b1;
        end
      end
      CMD_TICK: grace_check(it.now_time);
      default: begin
        if (term_kind == TERM_NONE) seq_bad = 1'b1;
        grace_check(it.now_time);
      end
    endcase
    s.malformed = seq_bad;
    s.started = seq_started;
    s.stop_pending = stop_seen;
    s.stop_acked = stop_acked;
    s.stop_refused = stop_refused;
    s.terminal_kind = term_kind;
    s.progress_count = progress_iters;
    s.final_iterations = term_iters;
    s.final_value = term_value;
    s.dropped_count = last_dropped;
    s.terminate_request = kill_req;
    return s;
  endfunction

  // A frame with the current magic and version; the unused fields are random.
  function automatic in_item_t frame_item(input logic [7:0] kind, input logic [31:0] iters,
                                          input logic [31:0] dropped, input logic [63:0] value);
    in_item_t it;
    it.command = CMD_FRAME;
    it.frame_magic = cfg_shadow.expected_magic;
    it.frame_version = cfg_shadow.expected_version;
    it.frame_kind = kind;
    it.frame_iterations = iters;
    it.frame_value = value;
    it.frame_dropped = dropped;
    it.now_time = $urandom;
    it.stop_reached = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // A non-frame command; the frame fields carry random junk.
  function automatic in_item_t command_item(input logic [1:0] cmd, input logic [31:0] now,
                                            input logic delivered);
    in_item_t it;
    it.command = cmd;
    it.frame_magic = $urandom;
    it.frame_version = 16'($urandom);
    it.frame_kind = 8'($urandom);
    it.frame_iterations = $urandom;
    it.frame_value = {$urandom, $urandom};
    it.frame_dropped = $urandom;
    it.now_time = now;
    it.stop_reached = delivered;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 72) gap = 0;
    else if (r < 97) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_snapshots.push_back(next_snapshot(it));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAGIC: cfg_shadow.expected_magic = val;
      REG_VERSION: cfg_shadow.expected_version = val[15:0];
      REG_TOTAL: cfg_shadow.total_iterations = val;
      default: cfg_shadow.stop_grace = val;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("t=%0d ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    out_item_t snap;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_snapshots.size() == 0) begin
        $display("t=%0d ns: result with nothing pending, got %h", $time, out_data);
        mismatches++;
      end else begin
        snap = pending_snapshots.pop_front();
        check_field("malformed", 64'(snap.malformed), 64'(out_data.malformed));
        check_field("started", 64'(snap.started), 64'(out_data.started));
        check_field("stop_pending", 64'(snap.stop_pending), 64'(out_data.stop_pending));
        check_field("stop_acked", 64'(snap.stop_acked), 64'(out_data.stop_acked));
        check_field("stop_refused", 64'(snap.stop_refused), 64'(out_data.stop_refused));
        check_field("terminal_kind", 64'(snap.terminal_kind),
                    64'(out_data.terminal_kind));
        check_field("progress_count", 64'(snap.progress_count),
                    64'(out_data.progress_count));
        check_field("final_iterations", 64'(snap.final_iterations),
                    64'(out_data.final_iterations));
        check_field("final_value", snap.final_value, out_data.final_value);
        check_field("dropped_count", 64'(snap.dropped_count),
                    64'(out_data.dropped_count));
        check_field("terminate_request", 64'(snap.terminate_request),
                    64'(out_data.terminate_request));
      end
    end
  end

  // Result-side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin : stall_gen
    int unsigned r;
    if (quiet_mode) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        out_stall <= 1'b0;
      end else if (r < 97) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("worker_frame_sequence_checker verification failed");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    send_item(command_item(CMD_TICK, 32'd0, 1'b0));
    send_item(command_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1));
  endtask

  // Opening of the session at the smallest target, then the widest settings.
  task automatic test_ready_and_limits();
    wait_quiet();
    write_reg(REG_TOTAL, 32'd1);
    send_item(frame_item(KIND_READY, 32'd0, 32'd0, 64'd0));
    // Iterations and dropped count both sit exactly on the target.
    send_item(frame_item(KIND_PROGRESS, 32'd1, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF));
    wait_quiet();
    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_VERSION, 32'h0000_FFFF);
    write_reg(REG_TOTAL, 32'hFFFF_FFFF);
    write_reg(REG_GRACE, 32'hFFFF_FFFF);
    send_item(frame_item(KIND_PROGRESS, 32'd2, 32'd1, 64'd0));
    send_item(command_item(CMD_TICK, 32'hFFFF_FFFF, 1'b0));
    send_item(frame_item(KIND_PROGRESS, 32'd3, 32'd1, {$urandom, $urandom}));
    wait_quiet();
    write_reg(REG_GRACE, 32'd0);
    write_reg(REG_MAGIC, $urandom);
    write_reg(REG_VERSION, $urandom);
    send_item(frame_item(KIND_PROGRESS, 32'd4, 32'd2, 64'd0));
  endtask

  // Legal progress frames with random steps, mixed with ticks and repeated stops.
  task automatic test_progress_stream(input int unsigned count);
    int unsigned r;
    int unsigned step;
    logic [31:0] d;
    logic [31:0] now;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 14) begin
        if (!stop_seen || cfg_shadow.stop_grace == 32'hFFFF_FFFF) begin
          now = $urandom;
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0) now = stop_at - $urandom_range(1, 50);
          else if (r == 1) now = $urandom;
          else if (cfg_shadow.stop_grace == 0) now = stop_at + $urandom_range(0, 10);
          else now = stop_at + $urandom_range(0, cfg_shadow.stop_grace - 1);
        end
        send_item(command_item(CMD_TICK, now, 1'($urandom_range(0, 1))));
      end else if (r < 17 && stop_seen) begin
        // Only the first stop request counts.
        send_item(command_item(CMD_STOP, $urandom, 1'($urandom_range(0, 1))));
      end else begin
        step = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 1 << 20);
        if (cfg_shadow.total_iterations - last_iters < step) step = 1;
        d = last_dropped;
        if ($urandom_range(0, 9) < 3 && d < cfg_shadow.total_iterations - 8)
          d = d + $urandom_range(1, 7);
        send_item(frame_item(KIND_PROGRESS, last_iters + step, d, {$urandom, $urandom}));
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_stop_request();
    int unsigned r;
    logic [31:0] grace;
    logic [31:0] stop_now;
    logic delivered;
    wait_quiet();
    r = $urandom_range(0, 9);
    if (r < 2) grace = 32'd0;
    else if (r == 2) grace = 32'hFFFF_FFFF;
    else grace = $urandom_range(200, 50000);
    write_reg(REG_GRACE, grace);
    write_reg(REG_MAGIC, $urandom);
    // With the longest grace only a stop at zero can ever expire.
    stop_now = (grace == 32'hFFFF_FFFF) ? 32'd0 : $urandom_range(1, 32'hF000_0000);
    delivered = ($urandom_range(0, 4) != 0);
    send_item(command_item(CMD_STOP, stop_now, delivered));
    send_item(command_item(CMD_STOP, stop_now + 5, !delivered));
    if (grace != 0) send_item(command_item(CMD_TICK, stop_now + grace - 1, 1'b0));
    if (stop_now != 0) send_item(command_item(CMD_TICK, stop_now - 1, 1'b0));
  endtask

  task automatic test_stop_answer();
    // The grace runs out exactly here.
    send_item(command_item(CMD_TICK, stop_at + cfg_shadow.stop_grace, 1'b0));
    wait_quiet();
    write_reg(REG_VERSION, $urandom);
    send_item(frame_item(($urandom_range(0, 1) == 1) ? KIND_STOPACK : KIND_STOPIGN,
                         last_iters + $urandom_range(0, 3), last_dropped, {$urandom, $urandom}));
    send_item(command_item(CMD_TICK, $urandom, 1'b0));
  endtask

  // Ends the session in one of several ways, legal or not.
  task automatic test_sequence_end();
    int unsigned pick;
    int unsigned bit_idx;
    in_item_t it;
    wait_quiet();
    pick = $urandom_range(0, 12);
    if (pick == 6 && $urandom_range(0, 1) == 1)
      write_reg(REG_TOTAL, 32'd0);
    else if (pick == 6 || pick == 8 || $urandom_range(0, 1) == 1)
      write_reg(REG_TOTAL, last_iters + $urandom_range(1, 4096));
    bit_idx = $urandom_range(0, 15);
    it = frame_item(KIND_PROGRESS, last_iters + 1, last_dropped, {$urandom, $urandom});
    case (pick)
      0, 1, 2: begin
        if (stop_acked)
          it = frame_item(KIND_CANCELLED, last_iters + $urandom_range(0, 1), last_dropped,
                          {$urandom, $urandom});
        else
          it = frame_item(KIND_COMPLETED, cfg_shadow.total_iterations, last_dropped,
                          {$urandom, $urandom});
      end
      3: it.command = CMD_EOS;
      4: it.frame_magic[bit_idx * 2] = ~it.frame_magic[bit_idx * 2];
      5: it.frame_version[bit_idx] = ~it.frame_version[bit_idx];
      6: it.frame_iterations = cfg_shadow.total_iterations + 1;
      7: it.frame_iterations = last_iters - 1;
      8: it.frame_dropped = cfg_shadow.total_iterations + 1;
      9: it.frame_dropped = last_dropped - 1;
      10: it.frame_kind = 8'($urandom_range(6, 255));
      11: it.frame_iterations = last_iters;
      default: begin
        // A second answer to the stop, or a cancel that was never acknowledged.
        it = frame_item(stop_acked ? KIND_STOPIGN : KIND_CANCELLED, last_iters, last_dropped,
                        64'd0);
      end
    endcase
    send_item(it);
    send_item(command_item(CMD_EOS, $urandom, 1'($urandom_range(0, 1))));
    // Frames after the end of the stream are still checked.
    send_item(frame_item(KIND_PROGRESS, last_iters + 1, last_dropped, 64'd0));
    send_item(command_item(CMD_TICK, $urandom, 1'b0));
  endtask

  task automatic test_noise();
    for (int unsigned i = 0; i < 40; i++)
      send_item(command_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1))));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_ready_and_limits();
    test_progress_stream(420);
    test_stop_request();
    test_progress_stream(420);
    test_stop_answer();
    if (stop_refused) test_progress_stream(120);
    test_sequence_end();
    test_noise();
    wait_quiet();
    if (mismatches == 0) begin
      $display("worker_frame_sequence_checker verification clean");
    end else begin
      $display("worker_frame_sequence_checker verification failed");
    end
    $finish;
  end

endmodule

// ===== worker_frame_sequence_checker.f =====
rtl/wfsc_pkg.sv
rtl/wfsc_cfg_regs.sv
rtl/wfsc_core.sv
rtl/worker_frame_sequence_checker.sv
tb/sv/worker_frame_sequence_checker_tb.sv
